// ----- sv/nqb_pkg.sv -----
package nqb_pkg;

    // Widths of the configuration register and the item fields.
    localparam int BS_W    = 5;
    localparam int FIRST_W = 4;
    localparam int SOL_W   = 24;
    localparam int FAIL_W  = 32;

    // Board size limits and reset value.
    localparam logic [BS_W-1:0] SIDE_MIN   = 5'd4;
    localparam logic [BS_W-1:0] SIDE_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // load a new start row and clear the counts
        logic step;      // advance the search by one node
        logic load_out;  // copy the counts into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // search tree exhausted
    } dp_sts_t;

endpackage

// ----- sv/nqb_ctrl.sv -----
module nqb_ctrl
    import nqb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next-state and command decode.
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sts.done) begin
                    if (out_free) begin
                        cmd.load_out   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/nqb_dpath.sv -----
module nqb_dpath
    import nqb_pkg::*;
#(
    parameter int MAX_BOARD = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [BS_W-1:0]    cfg_wdata,
    input  logic [FIRST_W-1:0] first_row,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output logic [SOL_W-1:0]   out_sol,
    output logic [FAIL_W-1:0]  out_fail,
    output logic               out_bad
);

    localparam int COL_W = $clog2(MAX_BOARD);
    localparam int CMP_W = COL_W + 2;

    logic [BS_W-1:0]      side_reg;

    // Current column: untried free rows and the threat masks for it.
    logic [COL_W-1:0]     col_reg;
    logic [MAX_BOARD-1:0] free_reg;
    logic [MAX_BOARD-1:0] rows_reg;
    logic [MAX_BOARD-1:0] dmain_reg;
    logic [MAX_BOARD-1:0] danti_reg;
    logic [SOL_W-1:0]     sol_reg;
    logic [FAIL_W-1:0]    fail_reg;
    logic                 bad_reg;

    // Parent frames, one per column.
    logic [MAX_BOARD-1:0] stk_free  [MAX_BOARD];
    logic [MAX_BOARD-1:0] stk_rows  [MAX_BOARD];
    logic [MAX_BOARD-1:0] stk_dmain [MAX_BOARD];
    logic [MAX_BOARD-1:0] stk_danti [MAX_BOARD];

    logic [MAX_BOARD-1:0] start_free;
    logic [MAX_BOARD-1:0] start_rows;
    logic                 start_bad;
    logic [MAX_BOARD-1:0] pick;
    logic [MAX_BOARD-1:0] free_rem;
    logic [MAX_BOARD-1:0] child_rows;
    logic [MAX_BOARD-1:0] child_dmain;
    logic [MAX_BOARD-1:0] child_danti;
    logic [MAX_BOARD-1:0] child_free;
    logic [CMP_W-1:0]     next_col;
    logic                 last_col;
    logic [COL_W-1:0]     pop_idx;

    // Start row decode: one-hot queen in column zero, rows beyond the board
    // marked as threatened.
    assign start_bad = {1'b0, first_row} >= side_reg;
    always_comb begin
        for (int i = 0; i < MAX_BOARD; i++) begin
            start_free[i] = !start_bad && (FIRST_W'(i) == first_row)
                            && (i < (1 << FIRST_W));
            start_rows[i] = (BS_W'(i) >= side_reg) || (i >= (1 << BS_W));
        end
    end

    // Take the lowest untried row and build the next column's threats.
    assign pick        = free_reg & (~free_reg + MAX_BOARD'(1));
    assign free_rem    = free_reg & ~pick;
    assign child_rows  = rows_reg | pick;
    assign child_dmain = (dmain_reg | pick) << 1;
    assign child_danti = (danti_reg | pick) >> 1;
    assign child_free  = ~(child_rows | child_dmain | child_danti);
    assign next_col    = CMP_W'(col_reg) + CMP_W'(1);
    assign last_col    = next_col >= CMP_W'(side_reg);
    assign pop_idx     = col_reg - COL_W'(1);

    assign sts.done = (free_reg == '0) && (col_reg == '0);

    // Board size register; out-of-range writes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_RESET;
        end else if (cfg_we && cfg_wdata >= SIDE_MIN
                     && 32'(cfg_wdata) <= 32'(MAX_BOARD)) begin
            side_reg <= cfg_wdata;
        end
    end

    // Search engine: one placement try or one backtrack per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            col_reg   <= '0;
            free_reg  <= start_free;
            rows_reg  <= start_rows;
            dmain_reg <= '0;
            danti_reg <= '0;
            sol_reg   <= '0;
            fail_reg  <= '0;
            bad_reg   <= start_bad;
        end else if (cmd.step) begin
            if (free_reg == '0) begin
                // Column exhausted: return to the parent frame.
                col_reg   <= pop_idx;
                free_reg  <= stk_free[pop_idx];
                rows_reg  <= stk_rows[pop_idx];
                dmain_reg <= stk_dmain[pop_idx];
                danti_reg <= stk_danti[pop_idx];
            end else if (last_col) begin
                free_reg <= free_rem;
                if (sol_reg != '1) begin
                    sol_reg <= sol_reg + SOL_W'(1);
                end
            end else if (child_free == '0) begin
                free_reg <= free_rem;
                if (fail_reg != '1) begin
                    fail_reg <= fail_reg + FAIL_W'(1);
                end
            end else begin
                // Descend: save this frame and move to the next column.
                stk_free[col_reg]  <= free_rem;
                stk_rows[col_reg]  <= rows_reg;
                stk_dmain[col_reg] <= dmain_reg;
                stk_danti[col_reg] <= danti_reg;
                col_reg            <= col_reg + COL_W'(1);
                free_reg           <= child_free;
                rows_reg           <= child_rows;
                dmain_reg          <= child_dmain;
                danti_reg          <= child_danti;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_sol  <= sol_reg;
            out_fail <= fail_reg;
            out_bad  <= bad_reg;
        end
    end

endmodule

// ----- sv/n_queens_backtrack_counter.sv -----
// The search makes one placement try or one backtrack per step, then loads its counts
// into the output register, where the result is valid; a bad start row goes straight there.
// One item is searched at a time; the next is taken once the last result is loaded,
// so taking it is delayed while the output waits.
// Reset (aresetn, synchronous, active low) empties the output register, idles the
// controller and sets the board size to 16.
module n_queens_backtrack_counter
    import nqb_pkg::*;
#(
    parameter int MAX_BOARD = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [BS_W-1:0] cfg_wdata,   // board size
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,     // [3:0] first_row
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [55:0]     m_tdata,     // [23:0] solution_count, [55:24] failure_count
    output logic [0:0]      m_tuser      // [0] bad_start
);

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [SOL_W-1:0]  out_sol;
    logic [FAIL_W-1:0] out_fail;
    logic              out_bad;

    nqb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    nqb_dpath #(
        .MAX_BOARD (MAX_BOARD)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .first_row (s_tdata[FIRST_W-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_sol   (out_sol),
        .out_fail  (out_fail),
        .out_bad   (out_bad)
    );

    // Result item packing.
    assign m_tdata = {out_fail, out_sol};
    assign m_tuser = out_bad;

endmodule

// ----- dv/n_queens_backtrack_counter_test.sv -----
module n_queens_backtrack_counter_test
    import nqb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOARD_MAX = 16;
    // Offset that keeps the main-diagonal index of a square non-negative.
    localparam int DIAG_BIAS = BOARD_MAX - 1;
    localparam longint SOL_CAP  = (64'd1 << SOL_W) - 1;
    localparam longint FAIL_CAP = (64'd1 << FAIL_W) - 1;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 8;

    // Expected contents of one result item.
    typedef struct {
        logic [SOL_W-1:0]  sol;
        logic [FAIL_W-1:0] fail;
        logic              bad;
    } tally_t;

    // Keeps the board size seen by the block, predicts the counts for each
    // accepted start row and checks the results in order.
    class queens_scoreboard;
        logic [BS_W-1:0] side;
        tally_t          awaited[$];
        int              errors;
        int              starts;
        int              bad_starts;
        longint          solutions;

        function new();
            side       = SIDE_RESET;
            errors     = 0;
            starts     = 0;
            bad_starts = 0;
            solutions  = 0;
        endfunction

        // Sizes outside the legal range leave the register as it was.
        function void write_board(input logic [BS_W-1:0] value);
            if (value >= SIDE_MIN && value <= BOARD_MAX)
                side = value;
        endfunction

        // Depth-first search that places one queen per column. Column d
        // holds the threat masks left by the queens in columns 0 to d-1.
        function tally_t count_placements(input logic [FIRST_W-1:0] row);
            logic [31:0] rows_m [BOARD_MAX+1];
            logic [31:0] main_m [BOARD_MAX+1];
            logic [31:0] anti_m [BOARD_MAX+1];
            int          next_r [BOARD_MAX+1];
            bit          placed [BOARD_MAX+1];
            int          n;
            int          d;
            int          r;
            longint      sols;
            longint      fails;
            tally_t      t;
            n = int'(side);
            sols = 0;
            fails = 0;
            t.bad = (int'(row) >= n);
            if (!t.bad) begin
                // Rows at or above the board size start out threatened.
                rows_m[1] = ~((32'd1 << n) - 32'd1) | (32'd1 << row);
                main_m[1] = 32'd1 << (int'(row) + DIAG_BIAS);
                anti_m[1] = 32'd1 << row;
                next_r[1] = 0;
                placed[1] = 1'b0;
                d = 1;
                while (d >= 1) begin
                    if (next_r[d] < n) begin
                        r = next_r[d];
                        next_r[d]++;
                        if (!rows_m[d][r] && !main_m[d][r + DIAG_BIAS - d] &&
                            !anti_m[d][r + d]) begin
                            placed[d] = 1'b1;
                            if (d == n - 1) begin
                                sols++;
                            end else begin
                                rows_m[d+1] = rows_m[d] | (32'd1 << r);
                                main_m[d+1] = main_m[d] | (32'd1 << (r + DIAG_BIAS - d));
                                anti_m[d+1] = anti_m[d] | (32'd1 << (r + d));
                                next_r[d+1] = 0;
                                placed[d+1] = 1'b0;
                                d++;
                            end
                        end
                    end else begin
                        // A column with no free row is a dead end.
                        if (!placed[d])
                            fails++;
                        d--;
                    end
                end
            end
            t.sol  = (sols > SOL_CAP) ? SOL_CAP[SOL_W-1:0] : sols[SOL_W-1:0];
            t.fail = (fails > FAIL_CAP) ? FAIL_CAP[FAIL_W-1:0] : fails[FAIL_W-1:0];
            return t;
        endfunction

        function void note_start(input logic [FIRST_W-1:0] row);
            tally_t t;
            t = count_placements(row);
            awaited.insert(awaited.size(), t);
            starts++;
            if (t.bad)
                bad_starts++;
            solutions += t.sol;
        endfunction

        function void check_result(input logic [SOL_W-1:0] sol,
                                   input logic [FAIL_W-1:0] fail,
                                   input logic bad);
            tally_t t;
            if (awaited.size() == 0) begin
                $error("result item with nothing expected: solution_count %0d",
                       sol);
                errors++;
                return;
            end
            t = awaited.pop_front();
            if (sol !== t.sol) begin
                $error("solution_count: expected %0d, actual %0d", t.sol, sol);
                errors++;
            end
            if (fail !== t.fail) begin
                $error("failure_count: expected %0d, actual %0d", t.fail, fail);
                errors++;
            end
            if (bad !== t.bad) begin
                $error("bad_start: expected %0d, actual %0d", t.bad, bad);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [BS_W-1:0] cfg_wdata = '0;
    logic            s_tvalid  = 1'b0;
    logic            s_tready;
    logic [7:0]      s_tdata   = '0;     // [3:0] first_row
    logic            m_tvalid;
    logic            m_tready  = 1'b0;
    logic [55:0]     m_tdata;            // [23:0] solution_count, [55:24] failure_count
    logic [0:0]      m_tuser;            // [0] bad_start

    queens_scoreboard sb = new();

    // Idle control shared by the sender, the receiver and the sequence.
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int rx_hold = 0;

    n_queens_backtrack_counter #(.MAX_BOARD(BOARD_MAX)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Fixed limit on the whole run.
    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        int gap;
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 6);
            if (rx_hold > 0) begin
                gap += rx_hold;
                rx_hold = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata[23:0], m_tdata[55:24], m_tuser[0]);
        end
    end

    // Offer one start row and note it once the block takes it.
    task automatic send_start(input logic [FIRST_W-1:0] row);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, row};
        do @(posedge aclk); while (!s_tready);
        sb.note_start(row);
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_board(input logic [BS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_board(value);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int size;
        int big_phases;
        logic [FIRST_W-1:0] row;
        big_phases = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Smallest board: every row, plus rows just past and far past the edge.
        write_board(5'd4);
        for (int r = 0; r <= 4; r++)
            send_start(r[FIRST_W-1:0]);
        send_start(4'd15);
        settle();

        // Out-of-range sizes must leave the board at four.
        write_board(5'd3);
        write_board(5'd17);
        write_board(5'd31);
        write_board(5'd0);
        send_start(4'd1);
        send_start(4'd4);
        settle();

        write_board(5'd5);
        send_start(4'd0);
        send_start(4'd2);
        send_start(4'd5);
        settle();

        // Hold the result side off for a long time so the block backs up.
        write_board(5'd8);
        tx_calm = 1'b1;
        rx_hold = 3000;
        send_start(4'd0);
        send_start(4'd3);
        send_start(4'd7);
        send_start(4'd8);
        send_start(4'd15);
        tx_calm = 1'b0;
        settle();

        // A full-size search takes far too long to run, so the largest size
        // is only written; the larger searches that follow use 10 and 11.
        write_board(5'd16);
        write_board(5'd10);
        send_start(4'd0);
        send_start(4'd9);
        settle();
        write_board(5'd11);
        send_start(4'd5);
        settle();

        // Random phases: mostly legal start rows on small boards.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            size = $urandom_range(4, 10);
            if (size == 10) begin
                if (big_phases == 2)
                    size = $urandom_range(4, 9);
                else
                    big_phases++;
            end
            if ($urandom_range(0, 4) == 0)
                write_board(BS_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                       : $urandom_range(17, 31)));
            write_board(size[BS_W-1:0]);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (p == RANDOM_PHASES / 2)
                rx_hold = 250;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 3) == 0)
                    row = FIRST_W'($urandom_range(0, 15));
                else
                    row = FIRST_W'($urandom_range(0, size - 1));
                send_start(row);
            end
            settle();
        end

        repeat (20) @(posedge aclk);
        while (sb.pending() != 0) begin
            void'(sb.awaited.pop_front());
            $error("expected result item never arrived");
            sb.errors++;
        end

        $display("Ran %0d start rows on boards of 4 to 11 squares, %0d of them past the edge.",
                 sb.starts, sb.bad_starts);
        $display("Searches found %0d solutions in all; out-of-range sizes were written too.",
                 sb.solutions);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
